FILE: hw/rtl/smpd_pkg.sv
package smpd_pkg;

  localparam int unsigned NUM_PROTOCOLS = 5;
  localparam int unsigned PACKET_BYTES  = 5;
  localparam int unsigned QUEUE_DEPTH   = 2;

  localparam logic [7:0] BYTE_RESYNC   = 8'h80;
  localparam logic [7:0] BYTE_MID_DOWN = 8'h20;
  localparam logic [7:0] BYTE_MID_UP   = 8'h00;

  typedef enum logic [2:0] {
    PROTO_TWO_BTN   = 3'd0,
    PROTO_FIVE_BYTE = 3'd1,
    PROTO_SIGNMAG_A = 3'd2,
    PROTO_SIGNMAG_B = 3'd3,
    PROTO_BUS       = 3'd4
  } proto_e;

  typedef struct packed {
    logic [7:0] head_mask;
    logic [7:0] head_id;
    logic [7:0] data_mask;
    logic [7:0] data_id;
    logic [2:0] length;
  } proto_desc_t;

  // One queued job: a finished packet or a stray middle-button word.
  typedef struct packed {
    logic            stray;
    logic [2:0]      proto;
    logic [4:0][7:0] bytes;
  } smpd_pkt_t;

  typedef struct packed {
    logic full;
    logic empty;
  } smpd_queue_st_t;

  typedef struct packed {
    logic       push;
    logic [2:0] pos;
  } smpd_front_st_t;

  function automatic proto_desc_t proto_desc(logic [2:0] proto);
    proto_desc_t d;
    d = '{head_mask: 8'h00, head_id: 8'h00, data_mask: 8'h00, data_id: 8'h00, length: 3'd0};
    unique case (proto)
      PROTO_TWO_BTN:   d = '{head_mask: 8'h40, head_id: 8'h40, data_mask: 8'h40,
                             data_id: 8'h00, length: 3'd3};
      PROTO_FIVE_BYTE: d = '{head_mask: 8'hf8, head_id: 8'h80, data_mask: 8'h00,
                             data_id: 8'h00, length: 3'd5};
      PROTO_SIGNMAG_A: d = '{head_mask: 8'he0, head_id: 8'h80, data_mask: 8'h80,
                             data_id: 8'h00, length: 3'd3};
      PROTO_SIGNMAG_B: d = '{head_mask: 8'he0, head_id: 8'h80, data_mask: 8'h80,
                             data_id: 8'h00, length: 3'd3};
      PROTO_BUS:       d = '{head_mask: 8'hf8, head_id: 8'h80, data_mask: 8'h00,
                             data_id: 8'h00, length: 3'd5};
      default:         d = '{head_mask: 8'h00, head_id: 8'h00, data_mask: 8'h00,
                             data_id: 8'h00, length: 3'd0};
    endcase
    return d;
  endfunction

  function automatic logic [9:0] sext8(logic [7:0] v);
    return {{2{v[7]}}, v};
  endfunction

endpackage

FILE: hw/rtl/smpd_front.sv
module smpd_front (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [2:0]               proto_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [7:0]               rx_byte_i,
  input  smpd_pkg::smpd_queue_st_t queue_st_i,
  output logic                     push_o,
  output smpd_pkg::smpd_pkt_t      pkt_o,
  output smpd_pkg::smpd_front_st_t front_st_o
);
  import smpd_pkg::*;

  logic [2:0]      pos_q, pos_d;
  logic [4:0][7:0] bytes_q;
  logic [4:0][7:0] merged;
  proto_desc_t     desc;
  logic            known;
  logic            drop;
  logic [2:0]      pos_eff;
  logic [2:0]      idx;
  logic [2:0]      next_cnt;
  logic            skip;
  logic            stray;
  logic            complete;
  logic            accept;

  assign in_stall_o = queue_st_i.full;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    desc     = proto_desc(proto_i);
    known    = proto_i < 3'(NUM_PROTOCOLS);
    drop     = (pos_q != 3'd0) &&
               (((rx_byte_i & desc.data_mask) != desc.data_id) || rx_byte_i == BYTE_RESYNC);
    pos_eff  = drop ? 3'd0 : pos_q;
    skip     = (pos_eff == 3'd0) && ((rx_byte_i & desc.head_mask) != desc.head_id);
    stray    = skip && proto_i == PROTO_TWO_BTN &&
               (rx_byte_i == BYTE_MID_DOWN || rx_byte_i == BYTE_MID_UP);
    // clamp to the last slot if the protocol changed under a long packet
    idx      = (pos_eff > 3'(PACKET_BYTES - 1)) ? 3'(PACKET_BYTES - 1) : pos_eff;
    next_cnt = idx + 3'd1;
    complete = !skip && next_cnt >= desc.length;

    merged      = bytes_q;
    merged[idx] = rx_byte_i;

    pos_d = pos_q;
    if (accept && known) begin
      if (skip || complete) begin
        pos_d = 3'd0;
      end else begin
        pos_d = next_cnt;
      end
    end

    push_o      = accept && known && (stray || complete);
    pkt_o.stray = stray;
    pkt_o.proto = proto_i;
    pkt_o.bytes = merged;
    if (stray) begin
      pkt_o.bytes[0] = rx_byte_i;
    end

    front_st_o.push = push_o;
    front_st_o.pos  = pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= 3'd0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && known && !skip) begin
      bytes_q[idx] <= rx_byte_i;
    end
  end

endmodule

FILE: hw/rtl/smpd_fifo.sv
module smpd_fifo #(
  parameter int unsigned Depth = smpd_pkg::QUEUE_DEPTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     push_i,
  input  smpd_pkg::smpd_pkt_t      data_i,
  input  logic                     pop_i,
  output smpd_pkg::smpd_pkt_t      data_o,
  output smpd_pkg::smpd_queue_st_t status_o
);
  import smpd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  smpd_pkt_t        entries_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.full  = count_q == CntW'(Depth);
  assign status_o.empty = count_q == '0;
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign data_o         = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: hw/rtl/smpd_back.sv
module smpd_back (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  smpd_pkg::smpd_pkt_t      pkt_i,
  input  smpd_pkg::smpd_queue_st_t queue_st_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [2:0]               buttons_o,
  output logic signed [9:0]        delta_x_o,
  output logic signed [9:0]        delta_y_o
);
  import smpd_pkg::*;

  logic       valid_q;
  logic [2:0] last_buttons_q;
  logic [2:0] btn_q;
  logic [9:0] dx_q, dy_q;
  logic [2:0] btn;
  logic [9:0] dx, dy;
  logic [7:0] b0, b1, b2, b3, b4;

  assign pop_o = !queue_st_i.empty && (!valid_q || !out_stall_i);

  always_comb begin
    b0 = pkt_i.bytes[0];
    b1 = pkt_i.bytes[1];
    b2 = pkt_i.bytes[2];
    b3 = pkt_i.bytes[3];
    b4 = pkt_i.bytes[4];
    btn = 3'd0;
    dx  = 10'd0;
    dy  = 10'd0;
    if (pkt_i.stray) begin
      btn = {last_buttons_q[2], b0[5], last_buttons_q[0]};
    end else begin
      unique case (pkt_i.proto)
        PROTO_TWO_BTN: begin
          // middle button is not in the packet: carry it over
          btn = {b0[5], last_buttons_q[1], b0[4]};
          dx  = {{2{b0[1]}}, b0[1:0], b1[5:0]};
          dy  = {{2{b0[3]}}, b0[3:2], b2[5:0]};
        end
        PROTO_FIVE_BYTE: begin
          btn = ~b0[2:0];
          dx  = sext8(b1) + sext8(b3);
          dy  = 10'd0 - (sext8(b2) + sext8(b4));
        end
        PROTO_SIGNMAG_A, PROTO_SIGNMAG_B: begin
          btn = b0[2:0];
          dx  = b0[4] ? {2'b00, b1} : 10'd0 - {2'b00, b1};
          dy  = b0[3] ? 10'd0 - {2'b00, b2} : {2'b00, b2};
        end
        default: begin
          btn = ~b0[2:0];
          dx  = sext8(b1);
          dy  = 10'd0 - sext8(b2);
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q        <= 1'b0;
      last_buttons_q <= 3'd0;
    end else begin
      if (pop_o) begin
        valid_q        <= 1'b1;
        last_buttons_q <= btn;
      end else if (!out_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      btn_q <= btn;
      dx_q  <= dx;
      dy_q  <= dy;
    end
  end

  assign out_valid_o = valid_q;
  assign buttons_o   = btn_q;
  assign delta_x_o   = $signed(dx_q);
  assign delta_y_o   = $signed(dy_q);

endmodule

FILE: hw/rtl/serial_mouse_packet_decoder_unit.sv
// Serial mouse packet decoder. Feed one received word per cycle on rx_byte_i; the
// decoder resynchronizes on headers, assembles packets for the selected protocol
// (0 two-button 3-byte, 1 five-byte, 2/3 sign-magnitude 3-byte, 4 bus 5-byte;
// codes 5 to 7 ignore all input) and emits one word of buttons, delta_x and
// delta_y per complete packet, plus a middle-button word for a stray 0x00 or
// 0x20 under protocol 0. A result passes through a QueueDepth-entry queue and then
// the output register, so input is taken every cycle as long as results drain.
// Write the protocol register only while idle.
module serial_mouse_packet_decoder_unit #(
  parameter int unsigned QueueDepth = smpd_pkg::QUEUE_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [7:0]        rx_byte_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [2:0]        buttons_o,
  output logic signed [9:0] delta_x_o,
  output logic signed [9:0] delta_y_o
);
  import smpd_pkg::*;

  logic           [2:0] proto_q;
  logic                 push;
  logic                 pop;
  smpd_pkt_t            front_pkt;
  smpd_pkt_t            head_pkt;
  smpd_queue_st_t       queue_st;
  smpd_front_st_t       front_st;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proto_q <= PROTO_TWO_BTN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      proto_q <= cfg_data_i;
    end
  end

  smpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .proto_i    (proto_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .queue_st_i (queue_st),
    .push_o     (push),
    .pkt_o      (front_pkt),
    .front_st_o (front_st)
  );

  smpd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (front_pkt),
    .pop_i    (pop),
    .data_o   (head_pkt),
    .status_o (queue_st)
  );

  smpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pkt_i       (head_pkt),
    .queue_st_i  (queue_st),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .buttons_o   (buttons_o),
    .delta_x_o   (delta_x_o),
    .delta_y_o   (delta_y_o)
  );

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_st.pos <= 3'(PACKET_BYTES - 1))
    else $error("packet position past last slot");

  a_unknown_proto_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && proto_q >= 3'(NUM_PROTOCOLS)) |->
      (!front_st.push ##1 $stable(front_st.pos)))
    else $error("unknown protocol changed decoder state");

  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_st.push |-> !queue_st.full)
    else $error("queue overrun");

  a_drain_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && queue_st.empty) |=> !out_valid_o)
    else $error("result repeated without queued work");

endmodule

FILE: test/smpd_motion_checker.sv
module smpd_motion_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  input  logic              cfg_ready_i,
  input  logic [2:0]        cfg_data_i,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [7:0]        rx_byte_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [2:0]        buttons_i,
  input  logic signed [9:0] delta_x_i,
  input  logic signed [9:0] delta_y_i,
  output int                fail_count_o,
  output int                pending_o
);
  import smpd_pkg::*;

  typedef struct packed {
    logic [2:0]        buttons;
    logic signed [9:0] dx;
    logic signed [9:0] dy;
  } motion_t;

  motion_t    due_motions[$];
  logic [2:0] protocol;
  logic [2:0] position;
  logic [2:0] last_btn;
  logic [7:0] frame[5];

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    fail_count_o++;
  endtask

  task automatic post_motion(input logic [2:0] btn, input logic signed [9:0] dx,
                             input logic signed [9:0] dy);
    motion_t m;
    m.buttons = btn;
    m.dx = dx;
    m.dy = dy;
    last_btn = btn;
    due_motions.push_back(m);
  endtask

  task automatic decode_word(input logic [7:0] b);
    logic [7:0] hmask, hid, dmask, did;
    logic [2:0] plen;
    logic [2:0] btn;
    logic signed [9:0] dx, dy;
    if (protocol > PROTO_BUS) return;
    case (protocol)
      PROTO_TWO_BTN: begin
        hmask = 8'h40; hid = 8'h40; dmask = 8'h40; did = 8'h00; plen = 3'd3;
      end
      PROTO_SIGNMAG_A, PROTO_SIGNMAG_B: begin
        hmask = 8'he0; hid = 8'h80; dmask = 8'h80; did = 8'h00; plen = 3'd3;
      end
      default: begin
        hmask = 8'hf8; hid = 8'h80; dmask = 8'h00; did = 8'h00; plen = 3'd5;
      end
    endcase
    // drop a partial packet on a bad data word or a resync word
    if (position != 3'd0 && (((b & dmask) != did) || b == BYTE_RESYNC)) position = 3'd0;
    if (position == 3'd0 && ((b & hmask) != hid)) begin
      if (protocol == PROTO_TWO_BTN && (b == BYTE_MID_DOWN || b == BYTE_MID_UP))
        post_motion({1'b0, b[5], 1'b0} | (last_btn & 3'b101), 10'sd0, 10'sd0);
      return;
    end
    if (position > 3'd4) position = 3'd4;
    frame[position] = b;
    position++;
    if (position < plen) return;
    position = 3'd0;
    case (protocol)
      PROTO_TWO_BTN: begin
        btn = {frame[0][5], last_btn[1], frame[0][4]};
        dx = $signed({frame[0][1:0], frame[1][5:0]});
        dy = $signed({frame[0][3:2], frame[2][5:0]});
      end
      PROTO_FIVE_BYTE: begin
        btn = ~frame[0][2:0];
        dx = $signed(frame[1]) + $signed(frame[3]);
        dy = -($signed(frame[2]) + $signed(frame[4]));
      end
      PROTO_SIGNMAG_A, PROTO_SIGNMAG_B: begin
        btn = frame[0][2:0];
        dx = frame[0][4] ? $signed({2'b00, frame[1]}) : -$signed({2'b00, frame[1]});
        dy = frame[0][3] ? -$signed({2'b00, frame[2]}) : $signed({2'b00, frame[2]});
      end
      default: begin
        btn = ~frame[0][2:0];
        dx = $signed(frame[1]);
        dy = -$signed(frame[2]);
      end
    endcase
    post_motion(btn, dx, dy);
  endtask

  task automatic check_word();
    motion_t want;
    if (due_motions.size() == 0) begin
      report_mismatch($sformatf("word with nothing due: buttons %0d dx %0d dy %0d",
                                buttons_i, delta_x_i, delta_y_i));
      return;
    end
    want = due_motions.pop_front();
    if (buttons_i !== want.buttons)
      report_mismatch($sformatf("buttons %0d, expected %0d", buttons_i, want.buttons));
    if (delta_x_i !== want.dx)
      report_mismatch($sformatf("delta_x %0d, expected %0d", delta_x_i, want.dx));
    if (delta_y_i !== want.dy)
      report_mismatch($sformatf("delta_y %0d, expected %0d", delta_y_i, want.dy));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      protocol = PROTO_TWO_BTN;
      position = 3'd0;
      last_btn = 3'd0;
      foreach (frame[i]) frame[i] = 8'h00;
      due_motions.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) check_word();
      if (cfg_valid_i && cfg_ready_i) protocol = cfg_data_i;
      if (in_valid_i && !in_stall_i) decode_word(rx_byte_i);
      pending_o = due_motions.size();
    end
  end

endmodule

FILE: test/tb.sv
module tb;
  import smpd_pkg::*;

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [2:0]        cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        rx_byte;
  logic              out_valid;
  logic              out_stall;
  logic [2:0]        buttons;
  logic signed [9:0] delta_x;
  logic signed [9:0] delta_y;
  int                fail_count;
  int                pending;

  bit                quiet = 1'b0;
  bit                squeeze = 1'b0;
  logic [7:0]        script[$];

  serial_mouse_packet_decoder_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .rx_byte_i   (rx_byte),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .buttons_o   (buttons),
    .delta_x_o   (delta_x),
    .delta_y_o   (delta_y)
  );

  smpd_motion_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .rx_byte_i    (rx_byte),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .buttons_i    (buttons),
    .delta_x_i    (delta_x),
    .delta_y_i    (delta_y),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  function automatic int frame_len(input logic [2:0] code);
    case (code)
      PROTO_TWO_BTN, PROTO_SIGNMAG_A, PROTO_SIGNMAG_B: return 3;
      PROTO_FIVE_BYTE, PROTO_BUS: return 5;
      default: return 1;
    endcase
  endfunction

  function automatic logic [7:0] head_word(input logic [2:0] code);
    logic [7:0] w;
    w = 8'($urandom);
    case (code)
      PROTO_TWO_BTN: w[6] = 1'b1;
      PROTO_FIVE_BYTE, PROTO_BUS: w[7:3] = 5'b10000;
      PROTO_SIGNMAG_A, PROTO_SIGNMAG_B: w[7:5] = 3'b100;
      default: ;
    endcase
    return w;
  endfunction

  function automatic logic [7:0] body_word(input logic [2:0] code);
    logic [7:0] w;
    do begin
      w = 8'($urandom);
      case (code)
        PROTO_TWO_BTN: w[6] = 1'b0;
        PROTO_SIGNMAG_A, PROTO_SIGNMAG_B: w[7] = 1'b0;
        default: ;
      endcase
    end while (w == BYTE_RESYNC);
    return w;
  endfunction

  task automatic send_word(input logic [7:0] b);
    int gap;
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    rx_byte  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic write_protocol(input logic [2:0] code);
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    // let a word that produces nothing clear the pipeline
    repeat (8) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= code;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic play_script(input logic [2:0] code);
    write_protocol(code);
    foreach (script[i]) send_word(script[i]);
  endtask

  task automatic run_phase(input logic [2:0] code, input int n_items);
    int count, r, k;
    count = 0;
    while (count < n_items) begin
      r = (code > PROTO_BUS) ? 9 : $urandom_range(0, 9);
      if (r <= 6) begin
        send_word(head_word(code));
        for (k = 1; k < frame_len(code); k++) send_word(body_word(code));
        count += frame_len(code);
      end else if (r == 7) begin
        // cut the packet short, sometimes with an explicit resync
        send_word(head_word(code));
        k = $urandom_range(0, frame_len(code) - 2);
        repeat (k) send_word(body_word(code));
        count += k + 1;
        if ($urandom_range(0, 1)) begin
          send_word(BYTE_RESYNC);
          count++;
        end
      end else if (r == 8 && code == PROTO_TWO_BTN) begin
        send_word($urandom_range(0, 1) ? BYTE_MID_DOWN : BYTE_MID_UP);
        count++;
      end else begin
        send_word(8'($urandom));
        count++;
      end
    end
    // leave a packet open across the protocol switch
    if (code <= PROTO_BUS && $urandom_range(0, 1)) begin
      send_word(head_word(code));
      send_word(body_word(code));
    end
  endtask

  initial begin : rx_side
    int burst;
    burst = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (squeeze) begin
        // hold off long enough for the queue to fill and stall the input
        out_stall <= 1'b1;
        repeat (60) @(negedge clk);
        squeeze = 1'b0;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : stimulus
    logic [2:0] code;
    rst_n     = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = 3'd0;
    in_valid  = 1'b0;
    rx_byte   = 8'h00;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // stray middle-button words, all-ones packet, resync, zero packet
    script = {8'h00, 8'h20, 8'h7f, 8'h3f, 8'h3f, 8'h40, 8'h80, 8'h40, 8'h00, 8'h00};
    play_script(PROTO_TWO_BTN);
    script = {8'h87, 8'h7f, 8'h7f, 8'h7f, 8'h7f};
    play_script(PROTO_FIVE_BYTE);
    script = {8'h9f, 8'h7f, 8'h7f};
    play_script(PROTO_SIGNMAG_A);
    script = {8'h80, 8'h00, 8'h00};
    play_script(PROTO_SIGNMAG_B);
    script = {8'h80, 8'hff, 8'h01, 8'h00, 8'h00};
    play_script(PROTO_BUS);
    script = {8'hff, 8'h00};
    play_script(3'd7);

    for (int ph = 0; ph < 10; ph++) begin
      if (ph == 0) code = PROTO_TWO_BTN;
      else if ($urandom_range(0, 7) == 0) code = 3'($urandom_range(5, 7));
      else code = 3'($urandom_range(0, 4));
      quiet = (ph == 9);
      write_protocol(code);
      if (ph == 0) squeeze = 1'b1;
      run_phase(code, (code > PROTO_BUS) ? 8 : 50);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (16) @(posedge clk);
    if (fail_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

  initial begin : watchdog
    #1200000;
    $display("Verification failed");
    $finish;
  end

endmodule
